@@ hdl/hrd_pkg.sv @@
// ----------------------------------------------------------------------------
// hrd_pkg
// Types and constants shared by the hit record deframer modules.
// ----------------------------------------------------------------------------
package hrd_pkg;

   // Record framing phase
   typedef enum logic [1:0] {
      PH_LENGTH = 2'd0,
      PH_ID     = 2'd1,
      PH_BODY   = 2'd2
   } phase_type;

   // Record class taken from the id word
   typedef enum logic [1:0] {
      CLS_DATA      = 2'd0,
      CLS_CONFIG    = 2'd1,
      CLS_TIMESTAMP = 2'd2,
      CLS_UNKNOWN   = 2'd3
   } class_type;

   localparam logic [31:0] ID_TIMESTAMP = 32'd101;
   localparam logic [31:0] ID_CONFIG    = 32'd100;
   localparam logic [31:0] ID_DATA      = 32'd102;

   // Result kinds
   localparam logic [2:0] KIND_HIT         = 3'd0;
   localparam logic [2:0] KIND_DATA_END    = 3'd1;
   localparam logic [2:0] KIND_CONFIG_END  = 3'd2;
   localparam logic [2:0] KIND_TS_END      = 3'd3;
   localparam logic [2:0] KIND_UNKNOWN_END = 3'd4;

   // Hit word layouts
   localparam logic [3:0] FMT_0 = 4'd0;
   localparam logic [3:0] FMT_3 = 4'd3;
   localparam logic [3:0] FMT_4 = 4'd4;
   localparam logic [3:0] FMT_5 = 4'd5;
   localparam logic [3:0] FMT_6 = 4'd6;
   localparam logic [3:0] FMT_7 = 4'd7;
   localparam logic [3:0] FMT_8 = 4'd8;

   typedef struct packed {
      logic [2:0] result_kind;
      logic [2:0] adc_value;
      logic [6:0] bco_value;
      logic [9:0] amplitude;
      logic [6:0] channel;
      logic       fpga_index;
      logic [1:0] module_index;
      logic       side_index;
      logic [4:0] chip_index;
      logic       word_mark;
      logic       buf_full;
      logic       checksum_ok;
   } result_type;

endpackage

@@ hdl/hrd_hit_unpack.sv @@
// ----------------------------------------------------------------------------
// hrd_hit_unpack
// Unpacks one payload word of a data record into hit fields per hit format.
// ----------------------------------------------------------------------------
module hrd_hit_unpack import hrd_pkg::*; (
   input  logic [31:0] word,
   input  logic [3:0]  hit_format,
   input  logic        first,
   output logic        hit_valid,
   output result_type  hit
);

   logic [4:0] raw_chip;
   logic [4:0] mod_chip;
   logic       low_chip;

   assign raw_chip = word[6:2];
   assign low_chip = (raw_chip < 5'd9);
   assign mod_chip = low_chip ? raw_chip : raw_chip - 5'd8;

   always_comb begin
      hit       = '0;
      hit_valid = 1'b0;
      case (hit_format)
         FMT_0: begin
            hit_valid     = word[0];
            hit.bco_value = {1'b0, word[29:24]};
            hit.adc_value = word[21:19];
            hit.channel   = word[17:11];
            hit.amplitude = word[10:1];
         end
         FMT_3, FMT_8: begin
            hit_valid     = !(hit_format == FMT_3 && first);
            hit.adc_value = word[31:29];
            hit.bco_value = {1'b0, word[28:23]};
            hit.amplitude = {4'b0, word[22:17]};
            hit.channel   = word[15:9];
            hit.fpga_index = word[7];
            if (hit_format == FMT_8) begin
               hit.chip_index = raw_chip;
            end else begin
               // fpga 0 reads modules 0/1, fpga 1 reads modules 3/2
               hit.module_index = word[7] ? (low_chip ? 2'd3 : 2'd2)
                                          : (low_chip ? 2'd0 : 2'd1);
               hit.side_index   = (mod_chip >= 5'd5);
               hit.chip_index   = (mod_chip < 5'd5) ? mod_chip : mod_chip - 5'd4;
            end
         end
         FMT_4: begin
            hit_valid     = !first;
            hit.amplitude = word[10:1];
            hit.bco_value = {1'b0, word[16:11]};
            hit.channel   = word[23:17];
            hit.adc_value = word[27:25];
            hit.word_mark = word[28];
            hit.buf_full  = word[29];
         end
         FMT_5: begin
            hit_valid     = !first;
            hit.amplitude = word[10:1];
            hit.bco_value = word[17:11];
            hit.channel   = word[24:18];
            hit.adc_value = word[28:26];
            hit.buf_full  = word[29];
         end
         FMT_6, FMT_7: begin
            hit_valid      = 1'b1;
            hit.adc_value  = {word[1], word[31:30]};
            hit.bco_value  = {word[9], word[28:23]};
            hit.amplitude  = {4'b0, word[22:17]};
            hit.channel    = {word[8], word[15:10]};
            hit.fpga_index = word[7];
            hit.chip_index = raw_chip;
            if (hit_format == FMT_7 && raw_chip > 5'd5) begin
               hit.chip_index = raw_chip - 5'd5;
               hit.fpga_index = 1'b1;
            end
         end
         default: begin
            hit_valid = 1'b0;
         end
      endcase
      hit.result_kind = KIND_HIT;
   end

endmodule

@@ hdl/hit_record_deframer.sv @@
// ----------------------------------------------------------------------------
// hit_record_deframer
// Splits a 32-bit record stream into hit and end-of-record transactions.
// ----------------------------------------------------------------------------
// Input channel req_*: one stream word per transaction (length, id, payload,
// checksum). Output channel rsp_*: at most one result per input word, either
// a hit (data records only) or an end-of-record marker with checksum status.
// A length word below 2 (signed) yields an unknown-id end at once.
// Configuration: APB register 0 (byte address 0) holds hit_format [3:0];
// write it only while the block is idle.
// Each result is registered, in the skid register if the output is stalled.
// Throughput: one word per cycle while req_stall is low; the framing state
// updates in the cycle of acceptance, so words may follow back to back.
// Backpressure: the output register is backed by a one-entry skid register.
// req_stall rises only while that skid entry is occupied, i.e. after the
// receiver has stalled a full output register and another result arrived.
// Reset (synchronous, active high): framing returns to expecting a length
// word, checksum and counters clear, hit_format returns to 0, and both
// output registers are emptied.
// ----------------------------------------------------------------------------
module hit_record_deframer import hrd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_stream_word,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_result_kind,
   output logic [2:0]  rsp_adc_value,
   output logic [6:0]  rsp_bco_value,
   output logic [9:0]  rsp_amplitude,
   output logic [6:0]  rsp_channel,
   output logic        rsp_fpga_index,
   output logic [1:0]  rsp_module_index,
   output logic        rsp_side_index,
   output logic [4:0]  rsp_chip_index,
   output logic        rsp_word_mark,
   output logic        rsp_buf_full,
   output logic        rsp_checksum_ok,
   // configuration
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   phase_type   phase_ff, phase_in;
   class_type   class_ff, class_in;
   logic [31:0] left_ff, left_in;
   logic [31:0] xor_ff, xor_in;
   logic        first_ff, first_in;
   logic [3:0]  fmt_ff;

   logic        rsp_valid_ff, skid_valid_ff;
   result_type  rsp_ff, skid_ff;

   logic        accept;
   logic        res_valid;
   result_type  res;
   logic        hit_valid;
   result_type  hit;
   logic        out_free;

   // ---------------- configuration ----------------
   assign pready = 1'b1;
   assign prdata = paddr[2] ? 32'd0 : {28'd0, fmt_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_0;
      end else if (psel && penable && pwrite && pready && !paddr[2]) begin
         fmt_ff <= pwdata[3:0];
      end
   end

   // ---------------- framing ----------------
   assign accept = req_valid && !req_stall;

   hrd_hit_unpack u_unpack (
      .word       (req_stream_word),
      .hit_format (fmt_ff),
      .first      (first_ff),
      .hit_valid  (hit_valid),
      .hit        (hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LENGTH;
         class_ff <= CLS_DATA;
         left_ff  <= '0;
         xor_ff   <= '0;
         first_ff <= 1'b1;
      end else begin
         phase_ff <= phase_in;
         class_ff <= class_in;
         left_ff  <= left_in;
         xor_ff   <= xor_in;
         first_ff <= first_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      class_in  = class_ff;
      left_in   = left_ff;
      xor_in    = xor_ff;
      first_in  = first_ff;
      res_valid = 1'b0;
      res       = '0;
      if (accept) begin
         case (phase_ff)
            PH_LENGTH: begin
               if (req_stream_word[31] || req_stream_word < 32'd2) begin
                  res_valid       = 1'b1;
                  res.result_kind = KIND_UNKNOWN_END;
               end else begin
                  xor_in   = req_stream_word;
                  left_in  = req_stream_word;
                  first_in = 1'b1;
                  phase_in = PH_ID;
               end
            end
            PH_ID: begin
               xor_in  = xor_ff ^ req_stream_word;
               left_in = left_ff - 32'd1;
               if (req_stream_word == ID_DATA) begin
                  class_in = CLS_DATA;
               end else if (req_stream_word == ID_CONFIG) begin
                  class_in = CLS_CONFIG;
               end else if (req_stream_word == ID_TIMESTAMP) begin
                  class_in = CLS_TIMESTAMP;
               end else begin
                  class_in = CLS_UNKNOWN;
               end
               phase_in = PH_BODY;
            end
            PH_BODY: begin
               if (left_ff <= 32'd1) begin
                  // checksum word
                  res_valid       = 1'b1;
                  res.result_kind = {1'b0, class_ff} + KIND_DATA_END;
                  res.checksum_ok = (xor_ff == req_stream_word);
                  phase_in        = PH_LENGTH;
                  left_in         = '0;
                  first_in        = 1'b1;
               end else begin
                  xor_in   = xor_ff ^ req_stream_word;
                  left_in  = left_ff - 32'd1;
                  first_in = 1'b0;
                  if (class_ff == CLS_DATA && hit_valid) begin
                     res_valid = 1'b1;
                     res       = hit;
                  end
               end
            end
            default: begin
               phase_in = PH_LENGTH;
            end
         endcase
      end
   end

   // ---------------- output register with skid ----------------
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff  <= skid_valid_ff || res_valid;
         skid_valid_ff <= 1'b0;
      end else if (res_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_ff <= skid_valid_ff ? skid_ff : res;
      end else if (res_valid) begin
         skid_ff <= res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_ff.result_kind;
   assign rsp_adc_value    = rsp_ff.adc_value;
   assign rsp_bco_value    = rsp_ff.bco_value;
   assign rsp_amplitude    = rsp_ff.amplitude;
   assign rsp_channel      = rsp_ff.channel;
   assign rsp_fpga_index   = rsp_ff.fpga_index;
   assign rsp_module_index = rsp_ff.module_index;
   assign rsp_side_index   = rsp_ff.side_index;
   assign rsp_chip_index   = rsp_ff.chip_index;
   assign rsp_word_mark    = rsp_ff.word_mark;
   assign rsp_buf_full     = rsp_ff.buf_full;
   assign rsp_checksum_ok  = rsp_ff.checksum_ok;

`ifndef SYNTHESIS
   // skid entry only ever sits behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held with empty output register");

   // skid is filled only when the receiver stalled a valid result
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid filled without a stalled output");

   // inside a record body at least the checksum word is still owed
   a_body_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY) |-> (left_ff != 32'd0))
      else $error("record body with no words left");

   // a new record always starts with its first payload word pending
   a_first_flag: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LENGTH) |-> first_ff)
      else $error("first payload flag clear between records");
`endif

endmodule
